// ===== src/cle_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cle_pkg
// shared types and constants of the cursor line editor
// ----------------------------------------------------------------------------
package cle_pkg;

  localparam int LINE_DEPTH_DEF = 64;
  localparam int CHAR_W         = 8;
  localparam int CMD_W          = 3;

  // key command codes
  typedef enum logic [CMD_W-1:0] {
    CMD_INSERT    = 3'd0,
    CMD_LEFT      = 3'd1,
    CMD_RIGHT     = 3'd2,
    CMD_BACKSPACE = 3'd3,
    CMD_FINISH    = 3'd4
  } cmd_e;

  // control sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,   // waiting for a key request
    ST_MOVE,   // cursor move: write back the char read last cycle
    ST_RD,     // line dump: read one char
    ST_WR,     // line dump: hand the char to the output register
    ST_EMPTY   // line dump of an empty line
  } state_e;

endpackage

// ===== src/cursor_line_editor_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cursor_line_editor_unit
// one-line text editor with a cursor, kept as a gap buffer in a single ram
// ----------------------------------------------------------------------------
//
//  channel  | dir | payload                                 | handshake
//  ---------+-----+-----------------------------------------+---------------
//  s_axis   | in  | tuser: cmd, tdata: key_char             | tvalid/tready
//  m_axis   | out | tdata: out_char, tlast: last_of_line,   | tvalid/tready
//           |     | tuser: line_empty                       |
//
//  insert and backspace are done when the request is taken; cursor left and
//  right read the ram, then write back into the other side of the gap.
//  finish reads each character from the single ram read port, then hands it
//  to the output register; an empty line hands out one beat flagged line_empty.
//  reset clears the counters and the sequencer; the store needs no clearing,
//  only written entries are ever read.
//  output stalls hold the dump in place; the input is taken only when idle.
//
// ----------------------------------------------------------------------------
module cursor_line_editor_unit import cle_pkg::*; #(
  parameter int LINE_DEPTH = LINE_DEPTH_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  // key requests
  input  logic              s_axis_tvalid_i,
  output logic              s_axis_tready_o,
  input  logic [CHAR_W-1:0] s_axis_tdata_i,   // [7:0] key_char
  input  logic [CMD_W-1:0]  s_axis_tuser_i,   // [2:0] cmd
  // finished line characters
  output logic              m_axis_tvalid_o,
  input  logic              m_axis_tready_i,
  output logic [CHAR_W-1:0] m_axis_tdata_o,   // [7:0] out_char
  output logic              m_axis_tlast_o,   // last_of_line
  output logic              m_axis_tuser_o    // [0] line_empty
);

  localparam int AW = $clog2(LINE_DEPTH);
  localparam int CW = $clog2(LINE_DEPTH + 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(LINE_DEPTH);
  localparam logic [CW-1:0] ONE_C   = CW'(1);

  state_e state_q, state_d;

  // gap buffer bookkeeping: chars before the cursor sit at the low end,
  // chars after the cursor at the high end of the store
  logic [CW-1:0] before_q, before_d;
  logic [CW-1:0] after_q, after_d;
  logic [CW-1:0] pos_q, pos_d;      // dump position within the line
  logic          dir_q, dir_d;      // pending move is a cursor left

  logic [CW-1:0] total;
  logic          in_fire;
  logic          out_free;
  logic          dump_last;
  cmd_e          cmd;

  // ram port
  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  logic [CHAR_W-1:0] mem_wdata;
  logic              mem_re;
  logic [AW-1:0]     mem_raddr;
  logic [CHAR_W-1:0] mem_rdata;

  // output register
  logic              out_valid_q, out_valid_d;
  logic [CHAR_W-1:0] out_char_q;
  logic              out_last_q, out_empty_q;
  logic              out_load;
  logic [CHAR_W-1:0] load_char;
  logic              load_last, load_empty;

  assign total     = before_q + after_q;
  assign cmd       = cmd_e'(s_axis_tuser_i);
  assign in_fire   = s_axis_tvalid_i && s_axis_tready_o;
  assign out_free  = !out_valid_q || m_axis_tready_i;
  assign dump_last = (pos_q == (total - ONE_C));

  assign s_axis_tready_o = (state_q == ST_IDLE);

  cle_ram #(
    .Depth (LINE_DEPTH),
    .AddrW (AW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          case (cmd)
            CMD_LEFT: begin
              if (before_q != '0) state_d = ST_MOVE;
            end
            CMD_RIGHT: begin
              if (after_q != '0) state_d = ST_MOVE;
            end
            CMD_FINISH: begin
              state_d = (total == '0) ? ST_EMPTY : ST_RD;
            end
            default: state_d = ST_IDLE;
          endcase
        end
      end
      ST_MOVE: state_d = ST_IDLE;
      ST_RD:   state_d = ST_WR;
      ST_WR: begin
        if (out_free) state_d = dump_last ? ST_IDLE : ST_RD;
      end
      ST_EMPTY: begin
        if (out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // ram accesses, counters and output loads
  always_comb begin
    mem_we     = 1'b0;
    mem_waddr  = '0;
    mem_wdata  = s_axis_tdata_i;
    mem_re     = 1'b0;
    mem_raddr  = '0;
    before_d   = before_q;
    after_d    = after_q;
    pos_d      = pos_q;
    dir_d      = dir_q;
    out_load   = 1'b0;
    load_char  = mem_rdata;
    load_last  = 1'b0;
    load_empty = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          case (cmd)
            CMD_INSERT: begin
              // full line drops the char
              if (total < DEPTH_C) begin
                mem_we    = 1'b1;
                mem_waddr = AW'(before_q);
                before_d  = before_q + ONE_C;
              end
            end
            CMD_LEFT: begin
              if (before_q != '0) begin
                mem_re    = 1'b1;
                mem_raddr = AW'(before_q - ONE_C);
                dir_d     = 1'b1;
              end
            end
            CMD_RIGHT: begin
              if (after_q != '0) begin
                mem_re    = 1'b1;
                mem_raddr = AW'(DEPTH_C - after_q);
                dir_d     = 1'b0;
              end
            end
            CMD_BACKSPACE: begin
              if (before_q != '0) before_d = before_q - ONE_C;
            end
            CMD_FINISH: pos_d = '0;
            default: pos_d = pos_q;
          endcase
        end
      end
      ST_MOVE: begin
        mem_we    = 1'b1;
        mem_wdata = mem_rdata;
        if (dir_q) begin
          mem_waddr = AW'(DEPTH_C - ONE_C - after_q);
          before_d  = before_q - ONE_C;
          after_d   = after_q + ONE_C;
        end else begin
          mem_waddr = AW'(before_q);
          before_d  = before_q + ONE_C;
          after_d   = after_q - ONE_C;
        end
      end
      ST_RD: begin
        mem_re    = 1'b1;
        // past the cursor the line continues at the high end of the store
        mem_raddr = (pos_q < before_q) ? AW'(pos_q) : AW'(pos_q + DEPTH_C - total);
      end
      ST_WR: begin
        if (out_free) begin
          out_load  = 1'b1;
          load_last = dump_last;
          if (dump_last) begin
            before_d = '0;
            after_d  = '0;
          end else begin
            pos_d = pos_q + ONE_C;
          end
        end
      end
      ST_EMPTY: begin
        if (out_free) begin
          out_load   = 1'b1;
          load_char  = '0;
          load_last  = 1'b1;
          load_empty = 1'b1;
        end
      end
      default: pos_d = pos_q;
    endcase
  end

  assign out_valid_d = out_load || (out_valid_q && !m_axis_tready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      before_q    <= '0;
      after_q     <= '0;
      pos_q       <= '0;
      dir_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      before_q    <= before_d;
      after_q     <= after_d;
      pos_q       <= pos_d;
      dir_q       <= dir_d;
      out_valid_q <= out_valid_d;
    end
  end

  // result payload, loaded only when the register is free
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_char_q  <= load_char;
      out_last_q  <= load_last;
      out_empty_q <= load_empty;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_char_q;
  assign m_axis_tlast_o  = out_last_q;
  assign m_axis_tuser_o  = out_empty_q;

endmodule

// ===== src/cle_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cle_ram
// character store: one write port, one read port, registered read data
// ----------------------------------------------------------------------------
module cle_ram import cle_pkg::*; #(
  parameter int Depth = LINE_DEPTH_DEF,
  parameter int AddrW = $clog2(Depth)
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [AddrW-1:0]  waddr_i,
  input  logic [CHAR_W-1:0] wdata_i,
  input  logic              re_i,
  input  logic [AddrW-1:0]  raddr_i,
  output logic [CHAR_W-1:0] rdata_o
);

  logic [CHAR_W-1:0] mem_q [Depth];
  logic [CHAR_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // read data holds until the next read
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
